// File: src/gn3d_pkg.sv
package gn3d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CELL_BITS     = 8;
    localparam int HASH_BITS     = 4;
    localparam int CORNERS       = 8;
    localparam int OUT_W         = 18;
    localparam int PIPE_DEPTH    = 11;

    typedef logic [CELL_BITS-1:0] t_cell;
    typedef logic [HASH_BITS-1:0] t_hash;

    localparam t_cell PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    function automatic t_cell perm_at(input t_cell idx);
        return PERM[idx];
    endfunction

endpackage

// File: src/gn3d_hash.sv
module gn3d_hash
    import gn3d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cell i_cx,
    input  t_cell i_cy,
    input  t_cell i_cz,
    output t_hash o_hash [CORNERS]
);

    t_cell r_a, r_b;
    t_cell r_cz;
    t_cell r_base [4];
    t_hash r_hash [CORNERS];

    t_cell n_base [4];

    always_comb begin
        n_base[0] = perm_at(r_a) + r_cz;
        n_base[1] = perm_at(r_b) + r_cz;
        n_base[2] = perm_at(r_a + 8'd1) + r_cz;
        n_base[3] = perm_at(r_b + 8'd1) + r_cz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a  <= perm_at(i_cx) + i_cy;
            r_b  <= perm_at(i_cx + 8'd1) + i_cy;
            r_cz <= i_cz;
            r_base <= n_base;
            for (int c = 0; c < CORNERS; c++) begin
                r_hash[c] <= HASH_BITS'(perm_at(r_base[c % 4] + t_cell'(c / 4)));
            end
        end
    end

    assign o_hash = r_hash;

endmodule

// File: src/gn3d_fade.sv
module gn3d_fade
    import gn3d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_frac,
    output logic [FRAC_BITS+1:0] o_fade
);

    localparam int FB = FRAC_BITS;
    localparam logic [63:0] HALF = 64'd1 << (FB - 1);

    logic [2*FB-1:0] r_ff;
    logic [FB-1:0]   r_f;
    logic [2*FB:0]   r_m;
    logic [FB+3:0]   r_q;
    logic [2*FB+4:0] r_prod;
    logic [FB+1:0]   r_fade;

    logic [2*FB:0]   n_t2s;
    logic [FB:0]     n_t2;
    logic [2*FB+5:0] n_p;
    logic [2*FB+5:0] n_ps;
    logic [2*FB+1:0] n_t3s;
    logic [FB:0]     n_t3;
    logic [2*FB+5:0] n_fs;

    always_comb begin
        n_t2s = {1'b0, r_ff} + HALF[2*FB:0];
        n_t2  = {1'b0, n_t2s[2*FB-1:FB]};
        n_p   = ((2*FB+6)'(10) << (2*FB)) + (2*FB+6)'(r_ff) * (2*FB+6)'(6)
              - ((2*FB+6)'(r_f) << FB) * (2*FB+6)'(15);
        n_ps  = n_p + HALF[2*FB+5:0];
        n_t3s = {1'b0, r_m} + HALF[2*FB+1:0];
        n_t3  = n_t3s[2*FB:FB];
        n_fs  = {1'b0, r_prod} + HALF[2*FB+5:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ff   <= i_frac * i_frac;
            r_f    <= i_frac;
            r_m    <= n_t2 * r_f;
            r_q    <= n_ps[2*FB+3:FB];
            r_prod <= n_t3 * r_q;
            r_fade <= n_fs[2*FB+1:FB];
        end
    end

    assign o_fade = r_fade;

endmodule

// File: src/gn3d_blend.sv
module gn3d_blend
    import gn3d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_hash                   i_hash [CORNERS],
    input  logic [FRAC_BITS-1:0]    i_fx,
    input  logic [FRAC_BITS-1:0]    i_fy,
    input  logic [FRAC_BITS-1:0]    i_fz,
    input  logic [FRAC_BITS+1:0]    i_u,
    input  logic [FRAC_BITS+1:0]    i_v,
    input  logic [FRAC_BITS+1:0]    i_w,
    output logic signed [OUT_W-1:0] o_noise
);

    localparam int FB = FRAC_BITS;
    localparam int OW = FB + 2;
    localparam int LW = FB + 4;
    localparam int PW = LW + FB + 4;
    localparam logic [63:0] HALF = 64'd1 << (FB - 1);
    localparam longint ONE = longint'(1) << FB;
    localparam longint HI = (2 * ONE > 131071) ? 131071 : 2 * ONE;
    localparam longint LO = (-2 * ONE < -131072) ? -131072 : -2 * ONE;

    function automatic logic signed [LW-1:0] grad(
        input t_hash h,
        input logic signed [OW-1:0] x,
        input logic signed [OW-1:0] y,
        input logic signed [OW-1:0] z
    );
        logic signed [LW-1:0] gu, gv;
        gu = (h < 4'd8) ? LW'(x) : LW'(y);
        gv = (h < 4'd4) ? LW'(y) : ((h == 4'd12 || h == 4'd14) ? LW'(x) : LW'(z));
        if (h[0]) gu = -gu;
        if (h[1]) gv = -gv;
        return gu + gv;
    endfunction

    function automatic logic signed [PW-1:0] mul_t(
        input logic [FB+1:0] t,
        input logic signed [LW-1:0] a,
        input logic signed [LW-1:0] b
    );
        logic signed [LW:0]   d;
        logic signed [PW-1:0] pr;
        d = (LW+1)'(b) - (LW+1)'(a);
        pr = $signed({1'b0, t}) * d;
        return pr;
    endfunction

    function automatic logic signed [LW-1:0] fin(
        input logic signed [LW-1:0] a,
        input logic signed [PW-1:0] p
    );
        logic signed [PW-1:0] s;
        s = p + $signed(HALF[PW-1:0]);
        return a + LW'(s >>> FB);
    endfunction

    logic signed [OW-1:0] n_ox [2], n_oy [2], n_oz [2];
    logic signed [LW-1:0] r_g [CORNERS];
    logic signed [LW-1:0] r_a1 [4], r_l1 [4];
    logic signed [PW-1:0] r_p1 [4];
    logic signed [LW-1:0] r_a2 [2], r_l2 [2];
    logic signed [PW-1:0] r_p2 [2];
    logic signed [LW-1:0] r_a3, r_r;
    logic signed [PW-1:0] r_p3;
    logic [FB+1:0]        r_v [2];
    logic [FB+1:0]        r_w [4];
    logic signed [OUT_W-1:0] r_noise;
    logic signed [63:0]   n_rx;

    always_comb begin
        n_ox[0] = OW'({1'b0, i_fx});
        n_oy[0] = OW'({1'b0, i_fy});
        n_oz[0] = OW'({1'b0, i_fz});
        n_ox[1] = n_ox[0] - OW'(ONE);
        n_oy[1] = n_oy[0] - OW'(ONE);
        n_oz[1] = n_oz[0] - OW'(ONE);
        n_rx    = 64'(r_r);
        if (n_rx > HI) n_rx = HI;
        if (n_rx < LO) n_rx = LO;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < CORNERS; c++) begin
                r_g[c] <= grad(i_hash[c], n_ox[c % 2], n_oy[(c / 2) % 2], n_oz[c / 4]);
            end
            for (int j = 0; j < 4; j++) begin
                r_a1[j] <= r_g[2*j];
                r_p1[j] <= mul_t(i_u, r_g[2*j], r_g[2*j+1]);
                r_l1[j] <= fin(r_a1[j], r_p1[j]);
            end
            r_v[0] <= i_v;
            r_v[1] <= r_v[0];
            r_w[0] <= i_w;
            for (int k = 1; k < 4; k++) r_w[k] <= r_w[k-1];
            for (int j = 0; j < 2; j++) begin
                r_a2[j] <= r_l1[2*j];
                r_p2[j] <= mul_t(r_v[1], r_l1[2*j], r_l1[2*j+1]);
                r_l2[j] <= fin(r_a2[j], r_p2[j]);
            end
            r_a3    <= r_l2[0];
            r_p3    <= mul_t(r_w[3], r_l2[0], r_l2[1]);
            r_r     <= fin(r_a3, r_p3);
            r_noise <= n_rx[OUT_W-1:0];
        end
    end

    assign o_noise = r_noise;

endmodule

// File: src/gradient_noise_3d.sv
// channel | direction | handshake            | payload
// in      | input     | i_valid / o_stall    | i_coord_x, i_coord_y, i_coord_z
// out     | output    | o_valid / i_stall    | o_noise_value
// one beat per cycle while the output is not stalled, through the hash, fade and blend pipeline
// the permutation rom is read combinationally in three hash stages
// synchronous active-low reset clears the valid bits only
// a stalled output beat freezes the whole pipeline; bubbles do not compress
module gradient_noise_3d
    import gn3d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [31:0]      i_coord_x,
    input  logic signed [31:0]      i_coord_y,
    input  logic signed [31:0]      i_coord_z,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_noise_value
);

    localparam int FB = FRAC_BITS;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [FB-1:0]         r_fx [3], r_fy [3], r_fz [3];
    logic                  en;
    t_hash                 hash [CORNERS];
    logic [FB+1:0]         fade_u, fade_v, fade_w;

    assign en      = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx[0] <= i_coord_x[FB-1:0];
            r_fy[0] <= i_coord_y[FB-1:0];
            r_fz[0] <= i_coord_z[FB-1:0];
            for (int k = 1; k < 3; k++) begin
                r_fx[k] <= r_fx[k-1];
                r_fy[k] <= r_fy[k-1];
                r_fz[k] <= r_fz[k-1];
            end
        end
    end

    gn3d_hash u_hash (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cx   (i_coord_x[FB +: CELL_BITS]),
        .i_cy   (i_coord_y[FB +: CELL_BITS]),
        .i_cz   (i_coord_z[FB +: CELL_BITS]),
        .o_hash (hash)
    );

    gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .i_clk (i_clk), .i_en (en), .i_frac (i_coord_x[FB-1:0]), .o_fade (fade_u)
    );

    gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .i_clk (i_clk), .i_en (en), .i_frac (i_coord_y[FB-1:0]), .o_fade (fade_v)
    );

    gn3d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
        .i_clk (i_clk), .i_en (en), .i_frac (i_coord_z[FB-1:0]), .o_fade (fade_w)
    );

    gn3d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_hash  (hash),
        .i_fx    (r_fx[2]),
        .i_fy    (r_fy[2]),
        .i_fz    (r_fz[2]),
        .i_u     (fade_u),
        .i_v     (fade_v),
        .i_w     (fade_w),
        .o_noise (o_noise_value)
    );

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without pending output");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0]) else $error("accepted beat lost");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld)) else $error("pipeline moved on stall");

endmodule
